// ===== src/trg_pkg.sv =====
// Shared types, constants and register codes for the taper ramp generator.
// No dependencies; the design files that use it take scoped names, the testbench files import it.
`default_nettype none

package trg_pkg;

  // Field widths
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 16;
  localparam int TYPE_W     = 3;
  localparam int LEN_W      = 13;
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = FRAC_W + LEN_W;
  localparam int STEP_W     = PROD_W + 1 - FRAC_SHIFT;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FRAC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TYPE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_FRACTION = 2'd2;

  // Ramp shapes
  localparam logic [TYPE_W-1:0] TYPE_ZEROS  = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_ONES   = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_STEP   = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_LINEAR = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_RCOS   = 3'd4;

  localparam logic [VAL_W-1:0] VALUE_ONE = 16'h8000;

  // Defaults for top-level parameters
  localparam int DEF_MAX_LENGTH = 4096;
  localparam int DEF_COS_STEPS  = 1024;

  localparam int MID_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_CONST,
    KIND_LINEAR,
    KIND_RCOS
  } trg_kind_t;

  // Settings derived from the config registers, held in a register of their own
  typedef struct packed {
    logic [TYPE_W-1:0] ramp_type;
    logic [LEN_W-1:0]  n;           // effective length
    logic [LEN_W-1:0]  d;           // n - 1, 0 when n is 0
    logic [STEP_W-1:0] step_start;  // first index at 1.0 for the step shape
  } trg_cfg_t;

  // Classified word between front and back
  typedef struct packed {
    trg_kind_t        kind;
    logic             in_range;
    logic [VAL_W-1:0] value;   // result for KIND_CONST
    logic [IDX_W-1:0] index;
  } trg_item_t;

endpackage

`default_nettype wire

// ===== src/trg_fifo.sv =====
// Small show-ahead FIFO built from registers.
// Depends on nothing; used for the front/back queue and the result queue.
`default_nettype none

module trg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNTW'(wr_en) - CNTW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;

endmodule

`default_nettype wire

// ===== src/trg_front.sv =====
// Front end: takes request words, checks range and sorts them by shape.
// Depends on trg_pkg; feeds the front/back queue.
`default_nettype none

module trg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  trg_pkg::trg_cfg_t           cfg,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [trg_pkg::IDX_W-1:0]   in_sample_index,
  output logic                        q_wr,
  output trg_pkg::trg_item_t          q_wdata,
  input  logic                        q_full
);

  logic                      front_v_r, front_v_nxt;
  logic [trg_pkg::IDX_W-1:0] idx_r;
  logic                      accept;

  assign q_wr    = front_v_r && !q_full;
  assign in_full = front_v_r && q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    front_v_nxt = front_v_r;
    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (q_wr) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_sample_index;
    end
  end

  // constant shapes resolve here; linear and raised cosine go to the divider only for in-range indexes when n > 1
  always_comb begin
    q_wdata          = '0;
    q_wdata.index    = idx_r;
    q_wdata.kind     = trg_pkg::KIND_CONST;
    q_wdata.in_range = (trg_pkg::LEN_W'(idx_r) < cfg.n);
    if (q_wdata.in_range) begin
      unique case (cfg.ramp_type)
        trg_pkg::TYPE_ONES: begin
          q_wdata.value = trg_pkg::VALUE_ONE;
        end
        trg_pkg::TYPE_STEP: begin
          if (trg_pkg::STEP_W'(idx_r) >= cfg.step_start) begin
            q_wdata.value = trg_pkg::VALUE_ONE;
          end
        end
        trg_pkg::TYPE_LINEAR: begin
          if (cfg.n > trg_pkg::LEN_W'(1)) begin
            q_wdata.kind = trg_pkg::KIND_LINEAR;
          end
        end
        trg_pkg::TYPE_RCOS: begin
          if (cfg.n > trg_pkg::LEN_W'(1)) begin
            q_wdata.kind = trg_pkg::KIND_RCOS;
          end
        end
        default: begin
          q_wdata.value = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/trg_back.sv =====
// Back end: pipelined divider (one quotient bit per stage), cosine table,
// result select and result queue. Depends on trg_pkg and trg_fifo.
`default_nettype none

module trg_back #(
  parameter int COS_STEPS = trg_pkg::DEF_COS_STEPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [trg_pkg::LEN_W-1:0]   ramp_d,
  input  logic                        q_empty,
  input  trg_pkg::trg_item_t          q_data,
  output logic                        q_rd,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [trg_pkg::VAL_W-1:0]   out_ramp_value,
  output logic                        out_in_range
);

  localparam int VAL_W     = trg_pkg::VAL_W;
  localparam int LIN_MUL   = 1 << VAL_W;
  localparam int RCOS_MUL  = 2 * COS_STEPS;
  localparam int MULT      = (RCOS_MUL > LIN_MUL) ? RCOS_MUL : LIN_MUL;
  localparam int NW        = $clog2(MULT) + trg_pkg::IDX_W + 1;
  localparam int CW        = NW + 1;
  localparam int AW        = $clog2(COS_STEPS + 1);
  localparam int QW        = (AW > VAL_W) ? AW : VAL_W;
  localparam int PIPE_LEN  = QW + 2;
  localparam int OUT_DEPTH = PIPE_LEN + 2;
  localparam int CRW       = $clog2(OUT_DEPTH + 1);
  localparam int RES_W     = VAL_W + 1;
  localparam int TAYLOR_TERMS = 20;

  localparam logic [63:0] Q60_ONE = 64'h1000000000000000;
  localparam logic [63:0] Q60_PI  = 64'h3243F6A8885A308D;

  // ---------------------------------------------------------------
  // Raised cosine table, built at elaboration in Q60 fixed point
  // ---------------------------------------------------------------
  typedef logic [VAL_W-1:0] rcos_tab_t [COS_STEPS+1];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // cos(x) for x in [0, pi/2], Taylor series
  function automatic logic [63:0] cos_q60(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [65:0] sum;
    logic signed [65:0] one_s;
    x2    = mul_q60(x, x);
    term  = Q60_ONE;
    one_s = $signed({2'b00, Q60_ONE});
    sum   = one_s;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = mul_q60(term, x2) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) begin
        sum = sum - $signed({2'b00, term});
      end else begin
        sum = sum + $signed({2'b00, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > one_s) begin
      sum = one_s;
    end
    return sum[63:0];
  endfunction

  // angle folded about pi/2 so the series only sees the first quadrant
  function automatic logic [VAL_W-1:0] rcos_entry(input logic [63:0] p);
    logic        upper;
    logic [63:0] q, theta, c, v, r;
    upper = (2 * p > 64'(COS_STEPS));
    q     = upper ? 64'(COS_STEPS) - p : p;
    theta = (Q60_PI / COS_STEPS) * q + ((Q60_PI % COS_STEPS) * q) / COS_STEPS;
    c     = cos_q60(theta);
    v     = upper ? Q60_ONE + c : Q60_ONE - c;
    r     = (v + (64'd1 << 45)) >> 46;
    return r[VAL_W-1:0];
  endfunction

  function automatic rcos_tab_t build_rcos_table();
    rcos_tab_t tab;
    for (int p = 0; p <= COS_STEPS; p++) begin
      tab[p] = rcos_entry(64'(p));
    end
    return tab;
  endfunction

  localparam rcos_tab_t RCOS_TABLE = build_rcos_table();

  // ---------------------------------------------------------------
  // Divider pipeline
  // ---------------------------------------------------------------
  typedef struct packed {
    trg_pkg::trg_kind_t kind;
    logic               in_range;
    logic [VAL_W-1:0]   value;
    logic [NW-1:0]      rem;
    logic [QW-1:0]      quo;
  } stage_t;

  typedef struct packed {
    trg_pkg::trg_kind_t kind;
    logic               in_range;
    logic [VAL_W-1:0]   value;
    logic [QW-1:0]      quo;
  } rstage_t;

  logic [trg_pkg::LEN_W:0] d2;
  logic                    issue;
  logic                    pop_acc;
  logic [CRW-1:0]          credit_r, credit_nxt;
  logic [QW:0]             v_r;
  stage_t                  st_r [QW+1];
  stage_t                  st0_nxt;
  rstage_t                 rs_r;
  logic                    rs_v_r;
  logic [AW-1:0]           rom_addr;
  logic [VAL_W-1:0]        rom_q_r;
  logic [VAL_W-1:0]        res_value;
  logic                    res_full;
  logic [RES_W-1:0]        res_rd;
  logic [CRW-1:0]          res_count;

  assign d2      = {ramp_d, 1'b0};
  assign pop_acc = out_pop && !out_empty;
  // only issue when the result queue has room for everything in flight
  assign issue   = !q_empty && (credit_r < CRW'(OUT_DEPTH));
  assign q_rd    = issue;
  assign credit_nxt = credit_r + CRW'(issue) - CRW'(pop_acc);

  // numerator: linear (65536 i + d), raised cosine (2 C i + d); divisor 2d
  always_comb begin
    st0_nxt          = '0;
    st0_nxt.kind     = q_data.kind;
    st0_nxt.in_range = q_data.in_range;
    st0_nxt.value    = q_data.value;
    unique case (q_data.kind)
      trg_pkg::KIND_LINEAR: begin
        st0_nxt.rem = (NW'(q_data.index) << VAL_W) + NW'(ramp_d);
      end
      trg_pkg::KIND_RCOS: begin
        st0_nxt.rem = NW'(q_data.index) * NW'(RCOS_MUL) + NW'(ramp_d);
      end
      default: begin
        st0_nxt.rem = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      v_r      <= '0;
      rs_v_r   <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      v_r      <= {v_r[QW-1:0], issue};
      rs_v_r   <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  // restoring division, MSB first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SHIFT = QW - 1 - j;
    logic [CW-1:0] dsh;
    logic [CW-1:0] rem_ext;
    logic          take;
    stage_t        nxt;

    assign dsh     = CW'(d2) << SHIFT;
    assign rem_ext = CW'(st_r[j].rem);
    assign take    = (rem_ext >= dsh);

    always_comb begin
      nxt = st_r[j];
      if (take) begin
        nxt.rem        = NW'(rem_ext - dsh);
        nxt.quo[SHIFT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      st_r[j+1] <= nxt;
    end
  end

  // table stage
  assign rom_addr = (st_r[QW].quo > QW'(COS_STEPS)) ? AW'(COS_STEPS)
                                                    : st_r[QW].quo[AW-1:0];

  always_ff @(posedge clk) begin
    rom_q_r     <= RCOS_TABLE[rom_addr];
    rs_r.kind     <= st_r[QW].kind;
    rs_r.in_range <= st_r[QW].in_range;
    rs_r.value    <= st_r[QW].value;
    rs_r.quo      <= st_r[QW].quo;
  end

  always_comb begin
    unique case (rs_r.kind)
      trg_pkg::KIND_LINEAR: res_value = rs_r.quo[VAL_W-1:0];
      trg_pkg::KIND_RCOS:   res_value = rom_q_r;
      default:              res_value = rs_r.value;
    endcase
  end

  trg_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rs_v_r),
    .wr_data ({rs_r.in_range, res_value}),
    .full    (res_full),
    .rd_en   (pop_acc),
    .rd_data (res_rd),
    .empty   (out_empty),
    .count   (res_count)
  );

  assign out_in_range   = res_rd[RES_W-1];
  assign out_ramp_value = res_rd[VAL_W-1:0];

  // credit scheme must keep the result queue from overflowing
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rs_v_r |-> !res_full)
    else $error("result queue written while full");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(OUT_DEPTH))
    else $error("credit count above result queue depth");

  a_credit_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(credit_r) == 32'(res_count) + $countones({v_r, rs_v_r}))
    else $error("credit count disagrees with words in flight");

endmodule

`default_nettype wire

// ===== src/taper_ramp_generator.sv =====
// Taper ramp generator top level: config registers, front end, queue, back end.
// Depends on trg_pkg, trg_front, trg_fifo and trg_back.
//
// Usage:
//  - Config: cfg_valid/cfg_ready write port, cfg_index 0 ramp_type, 1 ramp_length,
//    2 step_fraction; index 3 is ignored. cfg_ready is always high. Write only
//    while no requests are in flight; new settings apply to words pushed from
//    the next cycle on.
//  - Requests: push in_sample_index with in_push while in_full is low.
//  - Results: while out_empty is low, out_ramp_value (Q1.15, 0x8000 = 1.0) and
//    out_in_range show the oldest result; out_pop takes it.
//  - Throughput: one word per cycle, sustained while results are popped. The rate
//    is set by the divider pipeline, which retires one quotient bit per stage for
//    every word.
//  - Stall: the result queue holds every word the back end has started; when
//    it is out of room the back end stops issuing, the middle queue fills and
//    in_full rises. Nothing is dropped.
//  - Reset: synchronous, active low. Config and control registers clear to zero,
//    so every index reads as out of range with value 0 until ramp_length is written.
`default_nettype none

module taper_ramp_generator #(
  parameter int MAX_LENGTH = trg_pkg::DEF_MAX_LENGTH,
  parameter int COS_STEPS  = trg_pkg::DEF_COS_STEPS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [trg_pkg::IDX_W-1:0]       in_sample_index,
  // result channel
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [trg_pkg::VAL_W-1:0]       out_ramp_value,
  output logic                            out_in_range,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [trg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEN_W  = trg_pkg::LEN_W;
  localparam int MID_CW = $clog2(trg_pkg::MID_DEPTH + 1);
  // lengths above the cap saturate; a cap beyond the field width never bites
  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_LENGTH >= (1 << LEN_W)) ? {LEN_W{1'b1}} : LEN_W'(MAX_LENGTH);

  logic [trg_pkg::TYPE_W-1:0] type_r;
  logic [LEN_W-1:0]           len_r;
  logic [trg_pkg::FRAC_W-1:0] frac_r;
  logic                       cfg_wr;

  trg_pkg::trg_cfg_t          dcfg_r, dcfg_nxt;
  logic [LEN_W-1:0]           n_nxt;
  logic [trg_pkg::PROD_W:0]   step_sum;

  trg_pkg::trg_item_t         mid_wdata, mid_rdata;
  logic                       mid_wr, mid_full, mid_rd, mid_empty;
  logic [MID_CW-1:0]          mid_count;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= '0;
      len_r  <= '0;
      frac_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == trg_pkg::CFG_RAMP_TYPE) begin
        type_r <= cfg_data[trg_pkg::TYPE_W-1:0];
      end
      if (cfg_index == trg_pkg::CFG_RAMP_LENGTH) begin
        len_r <= cfg_data[LEN_W-1:0];
      end
      if (cfg_index == trg_pkg::CFG_STEP_FRACTION) begin
        frac_r <= cfg_data[trg_pkg::FRAC_W-1:0];
      end
    end
  end

  // derived settings, registered: effective length, d = n - 1,
  // step start = ceil(fraction * n / 65536)
  always_comb begin
    n_nxt    = (len_r > LEN_CAP) ? LEN_CAP : len_r;
    step_sum = (trg_pkg::PROD_W+1)'(frac_r) * (trg_pkg::PROD_W+1)'(n_nxt)
             + (trg_pkg::PROD_W+1)'((1 << trg_pkg::FRAC_SHIFT) - 1);
    dcfg_nxt.ramp_type  = type_r;
    dcfg_nxt.n          = n_nxt;
    dcfg_nxt.d          = (n_nxt == '0) ? '0 : n_nxt - 1'b1;
    dcfg_nxt.step_start = step_sum[trg_pkg::PROD_W:trg_pkg::FRAC_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcfg_r <= '0;
    end else begin
      dcfg_r <= dcfg_nxt;
    end
  end

  trg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (dcfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_index (in_sample_index),
    .q_wr            (mid_wr),
    .q_wdata         (mid_wdata),
    .q_full          (mid_full)
  );

  trg_fifo #(
    .WIDTH ($bits(trg_pkg::trg_item_t)),
    .DEPTH (trg_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_data (mid_rdata),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  trg_back #(
    .COS_STEPS (COS_STEPS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ramp_d         (dcfg_r.d),
    .q_empty        (mid_empty),
    .q_data         (mid_rdata),
    .q_rd           (mid_rd),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_ramp_value (out_ramp_value),
    .out_in_range   (out_in_range)
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_in_range) |-> (out_ramp_value == '0))
    else $error("out-of-range result with nonzero value");

  a_value_max: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_ramp_value <= trg_pkg::VALUE_ONE))
    else $error("result value above 1.0");

  a_len_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_index == trg_pkg::CFG_RAMP_LENGTH)
      |=> (len_r == $past(cfg_data[LEN_W-1:0])))
    else $error("ramp_length write not taken");

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_count == MID_CW'(trg_pkg::MID_DEPTH)) |-> !mid_wr)
    else $error("middle queue written while full");

endmodule

`default_nettype wire

// ===== tb/trg_checker.sv =====
// Checker for the taper ramp generator: tracks register writes, predicts every
// result word from the index pushed in and compares it with what comes out.
// Depends on trg_pkg for widths, shape codes and register indexes.
module trg_checker #(
  parameter int MAX_LENGTH = trg_pkg::DEF_MAX_LENGTH,
  parameter int COS_STEPS  = trg_pkg::DEF_COS_STEPS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic                            in_full,
  input  logic [trg_pkg::IDX_W-1:0]       in_sample_index,
  input  logic                            out_pop,
  input  logic                            out_empty,
  input  logic [trg_pkg::VAL_W-1:0]       out_ramp_value,
  input  logic                            out_in_range,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [trg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              words_checked,
  output int                              in_range_words
);
  timeunit 1ns;
  timeprecision 1ps;

  import trg_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             in_range;
    logic [IDX_W-1:0] index;
  } sample_t;

  // Q60 fixed point
  localparam logic [63:0] FIX_ONE = 64'h1000_0000_0000_0000;
  localparam logic [63:0] FIX_PI  = 64'h3243_F6A8_885A_308D;

  logic [TYPE_W-1:0] shape_q;
  logic [LEN_W-1:0]  length_q;
  logic [FRAC_W-1:0] frac_q;

  logic [VAL_W-1:0] cosine_lut [0:COS_STEPS];
  sample_t          expected_samples [$];

  function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Taylor series, angle in [0, pi/2]
  function automatic logic [63:0] fix_cos(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x2   = fix_mul(x, x);
    term = FIX_ONE;
    acc  = longint'(FIX_ONE);
    for (int k = 1; k <= 20; k++) begin
      term = fix_mul(term, x2) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc -= longint'(term);
      else            acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(FIX_ONE)) acc = longint'(FIX_ONE);
    return 64'(acc);
  endfunction

  // round(16384 * (1 - cos(pi * p / COS_STEPS))), folded about pi/2
  function automatic logic [VAL_W-1:0] cosine_entry(input int p);
    logic [63:0] steps;
    logic [63:0] q;
    logic [63:0] theta;
    logic [63:0] c;
    logic [63:0] v;
    logic        upper;
    steps = 64'(COS_STEPS);
    upper = (2 * p > COS_STEPS);
    q     = upper ? steps - 64'(p) : 64'(p);
    theta = (FIX_PI / steps) * q + ((FIX_PI % steps) * q) / steps;
    c     = fix_cos(theta);
    v     = upper ? FIX_ONE + c : FIX_ONE - c;
    v     = (v + (64'd1 << 45)) >> 46;
    return v[VAL_W-1:0];
  endfunction

  initial begin
    for (int p = 0; p <= COS_STEPS; p++) cosine_lut[p] = cosine_entry(p);
  end

  function automatic sample_t ramp_sample(input logic [IDX_W-1:0] idx);
    sample_t     r;
    logic [63:0] n;
    logic [63:0] i;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] p;
    r.index    = idx;
    r.value    = '0;
    r.in_range = 1'b0;
    n = (length_q > MAX_LENGTH) ? 64'(MAX_LENGTH) : 64'(length_q);
    i = 64'(idx);
    if (i >= n) return r;
    r.in_range = 1'b1;
    case (shape_q)
      TYPE_ONES: r.value = VALUE_ONE;
      TYPE_STEP: begin
        s = (64'(frac_q) * n + 64'd65535) >> 16;
        r.value = (i >= s) ? VALUE_ONE : '0;
      end
      TYPE_LINEAR: begin
        if (n > 1) begin
          d = n - 1;
          r.value = VAL_W'((64'd65536 * i + d) / (2 * d));
        end
      end
      TYPE_RCOS: begin
        if (n > 1) begin
          d = n - 1;
          p = (2 * i * 64'(COS_STEPS) + d) / (2 * d);
          if (p > 64'(COS_STEPS)) p = 64'(COS_STEPS);
          r.value = cosine_lut[p];
        end
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      shape_q  = '0;
      length_q = '0;
      frac_q   = '0;
      expected_samples.delete();
    end else begin
      if (!out_empty && out_pop) begin
        if (expected_samples.size() == 0) begin
          $error("result word with nothing pending: ramp_value %0d in_range %0d",
                 out_ramp_value, out_in_range);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          words_checked++;
          if (out_in_range) in_range_words++;
          if (out_ramp_value !== want.value) begin
            $error("ramp_value (index %0d): expected %0d, actual %0d",
                   want.index, want.value, out_ramp_value);
            mismatches++;
          end
          if (out_in_range !== want.in_range) begin
            $error("in_range (index %0d): expected %0d, actual %0d",
                   want.index, want.in_range, out_in_range);
            mismatches++;
          end
        end
      end
      // predict with the settings in force before any write at this edge
      if (in_push && !in_full) expected_samples.push_back(ramp_sample(in_sample_index));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RAMP_TYPE:     shape_q  = cfg_data[TYPE_W-1:0];
          CFG_RAMP_LENGTH:   length_q = cfg_data[LEN_W-1:0];
          CFG_STEP_FRACTION: frac_q   = cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

// ===== tb/tb_taper_ramp_generator.sv =====
// Top of the taper ramp generator testbench: clock, reset, register setup and
// request/result traffic; the verdict comes from the mismatch count of
// trg_checker. Depends on trg_pkg, trg_checker and taper_ramp_generator.
module tb_taper_ramp_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import trg_pkg::*;

  localparam int CYCLE_LIMIT    = 400_000;
  localparam int RANDOM_WORDS   = 1830;
  localparam int PRESSURE_WORDS = 300;   // continuous flood while results are held
  localparam int HOLD_CYCLES    = 400;   // long result-side hold-off
  localparam int SETTLE_CYCLES  = 30;    // longer than the push-to-result latency at default COS_STEPS

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;  // ignored by the block
  localparam logic [TYPE_W-1:0]    TYPE_SPARE_LO = 3'd5;  // 5..7 act as zeros
  localparam logic [TYPE_W-1:0]    TYPE_SPARE_HI = 3'd7;

  typedef enum int {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_TOGGLE} pop_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [IDX_W-1:0]      in_sample_index;
  logic                  out_pop;
  logic                  out_empty;
  logic [VAL_W-1:0]      out_ramp_value;
  logic                  out_in_range;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int words_checked;
  int in_range_words;

  int   cycle_count;
  int   full_cycles;
  int   words_sent;
  int   settings_used;
  logic hold_req = 1'b0;   // one-shot request for the long result hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  taper_ramp_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_index (in_sample_index),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_ramp_value  (out_ramp_value),
    .out_in_range    (out_in_range),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  trg_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_index (in_sample_index),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_ramp_value  (out_ramp_value),
    .out_in_range    (out_in_range),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .words_checked   (words_checked),
    .in_range_words  (in_range_words)
  );

  // Watchdog and back-pressure statistics.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_push && in_full) full_cycles++;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Cycle limit reached with %0d words still outstanding", outstanding);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request side helpers. Everything is driven on the falling edge; handshakes
  // are judged from values seen at the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until the block takes it. Returns on the falling
  // edge after acceptance with in_push still high, so a following word can go
  // out back to back without a bubble.
  task automatic send_word(input logic [IDX_W-1:0] idx);
    in_push         <= 1'b1;
    in_sample_index <= idx;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic pause_requests(input int cycles);
    if (cycles > 0) begin
      in_push <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Wait until every predicted word has come back. Always entered right after
  // send_word, so this is the only assignment to in_push in that step.
  task automatic drain();
    in_push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Register writes, only while nothing is in flight. valid stays up across
  // back-to-back writes. Sometimes the unused index is hit too, and the type
  // and length words carry junk above their field to check the masking.
  task automatic configure(input logic [TYPE_W-1:0] shape, input logic [LEN_W-1:0] len,
                           input logic [FRAC_W-1:0] frac);
    logic [CFG_IDX_W-1:0]  idx_list [4];
    logic [CFG_DATA_W-1:0] data_list [4];
    int                    cnt;
    cnt = 0;
    if ($urandom_range(0, 3) == 0) begin
      idx_list[cnt]  = CFG_UNUSED;
      data_list[cnt] = CFG_DATA_W'($urandom);
      cnt++;
    end
    idx_list[cnt]  = CFG_RAMP_TYPE;
    data_list[cnt] = CFG_DATA_W'(shape);
    if ($urandom_range(0, 1) == 1)
      data_list[cnt] = (CFG_DATA_W'($urandom) << TYPE_W) | CFG_DATA_W'(shape);
    cnt++;
    idx_list[cnt]  = CFG_RAMP_LENGTH;
    data_list[cnt] = CFG_DATA_W'(len);
    if ($urandom_range(0, 1) == 1)
      data_list[cnt] = (CFG_DATA_W'($urandom) << LEN_W) | CFG_DATA_W'(len);
    cnt++;
    idx_list[cnt]  = CFG_STEP_FRACTION;
    data_list[cnt] = CFG_DATA_W'(frac);
    cnt++;
    for (int w = 0; w < cnt; w++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[w];
      cfg_data  <= data_list[w];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Index mix: mostly inside the ramp, with weight on both ends, on the step
  // edge for the step shape, and a share past the end or anywhere at all.
  function automatic logic [IDX_W-1:0] pick_index(input int n, input logic [TYPE_W-1:0] shape,
                                                  input logic [FRAC_W-1:0] frac);
    int     r;
    int     v;
    longint edge_pos;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 10) begin
      v = $urandom_range(0, 4095);
    end else if (r < 20) begin
      v = (n < 4096) ? $urandom_range(n, 4095) : $urandom_range(0, 4095);
    end else if (r < 32) begin
      v = ($urandom_range(0, 1) == 1) ? 0 : n - 1;
    end else if (r < 45 && shape == TYPE_STEP) begin
      edge_pos = (longint'(frac) * n) >> 16;
      v = int'(edge_pos) + $urandom_range(0, 2) - 1;
      if (v < 0) v = 0;
      if (v > n - 1) v = n - 1;
    end else begin
      v = $urandom_range(0, n - 1);
    end
    return IDX_W'(v);
  endfunction

  // One phase of traffic under fixed settings: bursts of random length split by random
  // gaps (often none), or one unbroken burst when flooding; then wait for every result.
  task automatic run_words(input int count, input logic [TYPE_W-1:0] shape,
                           input logic [LEN_W-1:0] len, input logic [FRAC_W-1:0] frac,
                           input bit flood);
    int n;
    int sent;
    int burst;
    int r;
    n    = (len > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : int'(len);
    sent = 0;
    pause_requests($urandom_range(2, 6));
    while (sent < count) begin
      burst = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(20, 80);
      if (flood) burst = count;
      for (int b = 0; b < burst && sent < count; b++) begin
        send_word(pick_index(n, shape, frac));
        sent++;
      end
      if (sent < count && !flood) begin
        r = $urandom_range(0, 9);
        pause_requests(r < 4 ? 0 : (r < 8 ? $urandom_range(1, 4) : $urandom_range(5, 20)));
      end
    end
    drain();
  endtask

  task automatic random_phase(input int count, input bit flood);
    logic [TYPE_W-1:0] shape;
    logic [LEN_W-1:0]  len;
    logic [FRAC_W-1:0] frac;
    int                r;
    r = $urandom_range(0, 99);
    if      (r < 8)  shape = TYPE_ONES;
    else if (r < 15) shape = TYPE_ZEROS;
    else if (r < 40) shape = TYPE_STEP;
    else if (r < 65) shape = TYPE_LINEAR;
    else if (r < 90) shape = TYPE_RCOS;
    else             shape = TYPE_W'($urandom_range(TYPE_SPARE_LO, TYPE_SPARE_HI));
    r = $urandom_range(0, 99);
    if      (r < 5)  len = 0;
    else if (r < 10) len = 1;
    else if (r < 15) len = 2;
    else if (r < 50) len = LEN_W'($urandom_range(3, 64));
    else if (r < 80) len = LEN_W'($urandom_range(65, 4095));
    else if (r < 90) len = LEN_W'(DEF_MAX_LENGTH);
    else             len = LEN_W'($urandom_range(4097, 8191));   // saturates
    r = $urandom_range(0, 99);
    if      (r < 10) frac = 0;
    else if (r < 20) frac = FRAC_W'(65536);
    else if (r < 30) frac = FRAC_W'($urandom_range(65537, 131071));  // step past the end
    else             frac = FRAC_W'($urandom_range(0, 65535));
    configure(shape, len, frac);
    run_words(count, shape, len, frac, flood);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop on a pattern, picked anew at random after each random span,
  // from taking every word to sparse pops. Once, on request, it holds off for a
  // long stretch so the block fills up and pushes back on the request side.
  // ---------------------------------------------------------------------------
  initial begin
    pop_mode_e mode;
    int        span;
    out_pop = 1'b0;
    mode    = POP_ALWAYS;
    span    = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
      end
      if (span == 0) begin
        mode = pop_mode_e'($urandom_range(0, 3));
        span = $urandom_range(10, 150);
      end
      span--;
      case (mode)
        POP_ALWAYS: out_pop <= 1'b1;
        POP_HALF:   out_pop <= ($urandom_range(0, 1) == 1);
        POP_SPARSE: out_pop <= ($urandom_range(0, 3) == 0);
        default:    out_pop <= ~out_pop;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  target;
    int  count;
    bit  flooded;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_sample_index = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_RAMP_TYPE;
    cfg_data        = '0;
    flooded         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed ---------------------------------------------------------
    // Registers straight out of reset: length zero, every index out of range.
    send_word('0);
    send_word('1);
    drain();
    // Full-length ones, both ends of the index range.
    configure(TYPE_ONES, LEN_W'(DEF_MAX_LENGTH), '0);
    send_word('0);
    send_word('1);
    drain();
    // Length beyond the maximum saturates, so the top index is still inside.
    configure(TYPE_ONES, '1, '0);
    send_word('1);
    drain();
    // Length zero written explicitly.
    configure(TYPE_ONES, '0, '0);
    send_word('0);
    drain();
    // Length one: linear and raised cosine give 0 instead of dividing by zero.
    configure(TYPE_LINEAR, LEN_W'(1), '0);
    send_word('0);
    send_word(IDX_W'(1));
    drain();
    configure(TYPE_RCOS, LEN_W'(1), '0);
    send_word('0);
    drain();
    // Full-length linear and raised cosine: start, middle, end.
    configure(TYPE_LINEAR, LEN_W'(DEF_MAX_LENGTH), '0);
    send_word('0);
    send_word(IDX_W'(2047));
    send_word('1);
    drain();
    configure(TYPE_RCOS, LEN_W'(DEF_MAX_LENGTH), '0);
    send_word('0);
    send_word(IDX_W'(2048));
    send_word('1);
    drain();
    // Short raised cosine lands on the half-way point of the table.
    configure(TYPE_RCOS, LEN_W'(3), '0);
    send_word(IDX_W'(1));
    send_word(IDX_W'(2));
    drain();
    // Step at half of 100: 49 low, 50 high.
    configure(TYPE_STEP, LEN_W'(100), FRAC_W'(32768));
    send_word(IDX_W'(49));
    send_word(IDX_W'(50));
    drain();
    // Step at the very end, then past the end: the last sample stays low.
    configure(TYPE_STEP, LEN_W'(10), FRAC_W'(65536));
    send_word(IDX_W'(9));
    drain();
    configure(TYPE_STEP, LEN_W'(10), '1);
    send_word(IDX_W'(9));
    drain();
    // Unused shape code reads as zeros.
    configure(TYPE_SPARE_HI, LEN_W'(5), '0);
    send_word('0);
    drain();

    // --- random -----------------------------------------------------------
    // Phases of 20..80 words, the last cut to fit, under fresh settings; once
    // past the half-way mark one phase floods requests while the result side is held off.
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if (!flooded && words_sent > target - RANDOM_WORDS / 2) begin
        flooded  = 1'b1;
        hold_req = 1'b1;
        random_phase(PRESSURE_WORDS, 1'b1);
      end else begin
        count = $urandom_range(20, 80);
        if (count > target - words_sent) count = target - words_sent;
        random_phase(count, 1'b0);
      end
    end

    // Anything that shows up now has no request behind it.
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d request words under %0d register settings; %0d results checked, %0d in range.",
             words_sent, settings_used, words_checked, in_range_words);
    $display("Requests were held back by a full block for %0d cycles.", full_cycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/trg_pkg.sv
src/trg_fifo.sv
src/trg_front.sv
src/trg_back.sv
src/taper_ramp_generator.sv
tb/trg_checker.sv
tb/tb_taper_ramp_generator.sv
